FILE: src/polar_rectangular_converter_top_assert.svh
// Assertion macros for the polar / rectangular converter.
// Included by polar_rectangular_converter_top.sv; needs no other file.
`ifndef POLAR_RECTANGULAR_CONVERTER_TOP_ASSERT_SVH
`define POLAR_RECTANGULAR_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/prc_pkg.sv
// Shared types, constants and elaboration-time table builders for the
// polar / rectangular converter. No dependencies.
package prc_pkg;

    localparam int COORD_W  = 16;
    localparam int RESULT_W = 17;

    localparam int OUT_MAX   = 46341;
    localparam int ANGLE_MAX = 23040;

    localparam int HALF_TURN_DEG    = 180;
    localparam int QUARTER_TURN_DEG = 90;

    localparam int LEN_FRAC  = 8;   // input and output lengths
    localparam int ANG_FRAC  = 7;   // angles at the ports
    localparam int COMP_FRAC = 12;  // datapath floored to this before the gain multiply
    localparam int GAIN_FRAC = 30;
    localparam int COMP_SHIFT = GAIN_FRAC + COMP_FRAC - LEN_FRAC;

    localparam int ROM_FRAC = 40;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    typedef enum logic {
        REQ_RECT_TO_POLAR = 1'b0,
        REQ_POLAR_TO_RECT = 1'b1
    } req_type_t;

    // Restoring division, used only while building constants.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        int b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in radians, Q.60, truncated power series (i >= 1).
    function automatic logic [63:0] atan_rad_q60(input int i);
        logic [63:0] sum;
        logic [63:0] t;
        int k;
        int sh;
        sum = '0;
        for (k = 0; k < 31; k++)
        begin
            sh = i * (2 * k + 1);
            if (sh <= 60)
            begin
                t = udiv64((64'd1 << 60) >> sh, 64'(2 * k + 1));
                if (k[0])
                    sum = sum - t;
                else
                    sum = sum + t;
            end
        end
        return sum;
    endfunction

    // atan(2^-i) in degrees, rounded half up to dw fraction bits.
    function automatic logic [63:0] atan_entry(input int i, input int dw);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] r;
        int b;
        if (i == 0)
        begin
            q = 64'd45 << ROM_FRAC;
        end
        else
        begin
            num = (atan_rad_q60(i) >> 8) * 64'd180;
            den = PI_Q60 >> 8;
            q = udiv64(num, den);
            r = num - q * den;
            for (b = 0; b < ROM_FRAC; b++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q[0] = 1'b1;
                end
            end
        end
        return (q + (64'd1 << (ROM_FRAC - dw - 1))) >> (ROM_FRAC - dw);
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        int k;
        n = n_in;
        res = '0;
        bitv = 64'd1 << 62;
        for (k = 0; k < 32; k++)
        begin
            if (bitv > n)
                bitv = bitv >> 2;
        end
        for (k = 0; k < 32; k++)
        begin
            if (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // 1 / CORDIC gain, Q.30, truncated.
    function automatic logic [63:0] cordic_gain(input int iters);
        logic [63:0] p;
        int i;
        p = 64'd1 << 60;
        for (i = 0; i < iters; i++)
            p = p + (p >> (2 * i));
        return udiv64(64'd1 << 60, isqrt64(p));
    endfunction

endpackage

FILE: src/prc_if.sv
// Valid/ready channel interfaces for the converter's request and result sides.
// Depends on prc_pkg for field widths.
interface prc_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [prc_pkg::COORD_W-1:0]  coord_a;
    logic signed [prc_pkg::COORD_W-1:0]  coord_b;

    modport source (output valid, output req_type, output coord_a, output coord_b,
                    input ready);
    modport sink   (input valid, input req_type, input coord_a, input coord_b,
                    output ready);
endinterface

interface prc_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [prc_pkg::RESULT_W-1:0] out_a;
    logic signed [prc_pkg::RESULT_W-1:0] out_b;

    modport source (output valid, output out_a, output out_b, input ready);
    modport sink   (input valid, input out_a, input out_b, output ready);
endinterface

FILE: src/polar_rectangular_converter_top.sv
// Polar / rectangular converter, pipelined gain-compensated CORDIC.
// Depends on prc_pkg, prc_if.sv and polar_rectangular_converter_top_assert.svh.
//
// req (sink): req_type 0 takes x,y (Q7.8) and returns magnitude (Q8.8) and
//   atan2 angle in degrees (Q9.7, origin gives 0,0); req_type 1 takes a
//   magnitude (Q7.8) and angle (Q8.7 degrees) and returns x,y (Q8.8).
// rsp (source): out_a, out_b, saturated to +-46341 (angle to +-23040).
// A transfer happens on any edge with valid and ready both high.
// Pipeline: one input conditioning stage, one stage per CORDIC iteration,
//   one gain multiply stage, one rounding/saturation output register.
// Throughput: one pair per cycle while rsp is not stalled.
// Each stage has its own valid bit; a stage loads whenever it is empty or
//   its successor loads, so bubbles collapse and rsp stalls back up one
//   stage at a time. Input is refused only once every stage is full.
// Reset clears all valid bits; no item survives it.
`include "polar_rectangular_converter_top_assert.svh"

module polar_rectangular_converter_top #(
    parameter int ITERATIONS = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    prc_req_if.sink      req,
    prc_rsp_if.source    rsp
);

    localparam int XW  = DATA_WIDTH + 10;
    localparam int ZW  = DATA_WIDTH + 10;
    localparam int NST = ITERATIONS + 3;
    localparam int CW  = XW - (DATA_WIDTH - prc_pkg::COMP_FRAC);
    localparam int PW  = CW + 32;
    localparam int AW  = 18;
    localparam int RW  = prc_pkg::RESULT_W;

    localparam logic signed [ZW-1:0] HALF_TURN =
        ZW'(prc_pkg::HALF_TURN_DEG) <<< DATA_WIDTH;
    localparam logic signed [ZW-1:0] QUARTER_TURN =
        ZW'(prc_pkg::QUARTER_TURN_DEG) <<< DATA_WIDTH;
    localparam logic signed [ZW-1:0] ANG_RND =
        ZW'(1) <<< (DATA_WIDTH - prc_pkg::ANG_FRAC - 1);
    localparam logic signed [31:0] GAIN = 32'(prc_pkg::cordic_gain(ITERATIONS));
    localparam logic signed [PW-1:0] OUT_RND = PW'(1) <<< (prc_pkg::COMP_SHIFT - 1);
    localparam logic signed [PW-1:0] OUT_MAX_W   = PW'(prc_pkg::OUT_MAX);
    localparam logic signed [PW-1:0] ANGLE_MAX_W = PW'(prc_pkg::ANGLE_MAX);
    localparam logic signed [RW-1:0] OUT_MAX_S   = RW'(prc_pkg::OUT_MAX);
    localparam logic signed [RW-1:0] ANGLE_MAX_S = RW'(prc_pkg::ANGLE_MAX);

    typedef struct packed {
        prc_pkg::req_type_t      mode;
        logic                    zero;
        logic signed [XW-1:0]    x;
        logic signed [XW-1:0]    y;
        logic signed [ZW-1:0]    z;
    } iter_t;

    typedef struct packed {
        prc_pkg::req_type_t      mode;
        logic                    zero;
        logic signed [PW-1:0]    pa;
        logic signed [PW-1:0]    pb;
        logic signed [AW-1:0]    ang;
    } mul_t;

    function automatic logic signed [RW-1:0] sat(input logic signed [PW-1:0] v,
                                                 input logic signed [PW-1:0] lo,
                                                 input logic signed [PW-1:0] hi);
        logic signed [PW-1:0] c;
        c = v;
        if (v < lo)
            c = lo;
        else if (v > hi)
            c = hi;
        return c[RW-1:0];
    endfunction

    // ---------------- handshake ----------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] vld_in;
    logic [NST:0]   rdy;
    logic [NST-1:0] load;

    assign vld_in   = {vld_reg[NST-2:0], req.valid};
    assign rdy[NST] = rsp.ready;

    for (genvar k = 0; k < NST; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    assign load     = rdy[NST-1:0] & vld_in;
    assign vld_next = (vld_reg & ~rdy[NST-1:0]) | (vld_in & rdy[NST-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign req.ready = rdy[0];
    assign rsp.valid = vld_reg[NST-1];

    // ---------------- input conditioning ----------------
    iter_t st_reg  [0:ITERATIONS];
    iter_t st_next [0:ITERATIONS];
    iter_t s0_next;

    logic signed [XW-1:0] ax;
    logic signed [XW-1:0] bx;
    logic signed [ZW-1:0] bz;

    always_comb
    begin
        ax = signed'({{(XW-prc_pkg::COORD_W){req.coord_a[prc_pkg::COORD_W-1]}}, req.coord_a})
             <<< (DATA_WIDTH - prc_pkg::LEN_FRAC);
        bx = signed'({{(XW-prc_pkg::COORD_W){req.coord_b[prc_pkg::COORD_W-1]}}, req.coord_b})
             <<< (DATA_WIDTH - prc_pkg::LEN_FRAC);
        bz = signed'({{(ZW-prc_pkg::COORD_W){req.coord_b[prc_pkg::COORD_W-1]}}, req.coord_b})
             <<< (DATA_WIDTH - prc_pkg::ANG_FRAC);
        s0_next.mode = prc_pkg::req_type_t'(req.req_type);
        s0_next.zero = (req.coord_a == '0) && (req.coord_b == '0);
        if (req.req_type == prc_pkg::REQ_RECT_TO_POLAR)
        begin
            // left half-plane: turn by 180 degrees first
            if (ax < 0)
            begin
                s0_next.z = (bx >= 0) ? HALF_TURN : -HALF_TURN;
                s0_next.x = -ax;
                s0_next.y = -bx;
            end
            else
            begin
                s0_next.z = '0;
                s0_next.x = ax;
                s0_next.y = bx;
            end
        end
        else
        begin
            // fold angles beyond +-90 degrees, negating the magnitude
            s0_next.y = '0;
            if (bz > QUARTER_TURN)
            begin
                s0_next.z = bz - HALF_TURN;
                s0_next.x = -ax;
            end
            else if (bz < -QUARTER_TURN)
            begin
                s0_next.z = bz + HALF_TURN;
                s0_next.x = -ax;
            end
            else
            begin
                s0_next.z = bz;
                s0_next.x = ax;
            end
        end
    end

    assign st_next[0] = s0_next;

    // ---------------- CORDIC iterations ----------------
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(prc_pkg::atan_entry(i, DATA_WIDTH));

        iter_t                cur;
        iter_t                nxt;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic                 up;

        always_comb
        begin
            cur = st_reg[i];
            xs  = cur.x >>> i;
            ys  = cur.y >>> i;
            // up: rotate counterclockwise this step (y gains x >>> i)
            up  = (cur.mode == prc_pkg::REQ_POLAR_TO_RECT) ? !cur.z[ZW-1] : cur.y[XW-1];
            nxt = cur;
            if (up)
            begin
                nxt.x = cur.x - ys;
                nxt.y = cur.y + xs;
                nxt.z = cur.z - ATAN_I;
            end
            else
            begin
                nxt.x = cur.x + ys;
                nxt.y = cur.y - xs;
                nxt.z = cur.z + ATAN_I;
            end
        end

        assign st_next[i+1] = nxt;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= ITERATIONS; k++)
        begin
            if (load[k])
                st_reg[k] <= st_next[k];
        end
    end

    // ---------------- gain compensation multiply ----------------
    mul_t                 mul_reg;
    mul_t                 mul_next;
    iter_t                fin;
    logic signed [CW-1:0] xc;
    logic signed [CW-1:0] yc;
    logic signed [ZW-1:0] angw;

    always_comb
    begin
        fin  = st_reg[ITERATIONS];
        xc   = fin.x[XW-1:DATA_WIDTH-prc_pkg::COMP_FRAC];
        yc   = fin.y[XW-1:DATA_WIDTH-prc_pkg::COMP_FRAC];
        angw = (fin.z + ANG_RND) >>> (DATA_WIDTH - prc_pkg::ANG_FRAC);
        mul_next.mode = fin.mode;
        mul_next.zero = fin.zero;
        mul_next.pa   = PW'(xc) * PW'(GAIN);
        mul_next.pb   = PW'(yc) * PW'(GAIN);
        mul_next.ang  = angw[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[ITERATIONS+1])
            mul_reg <= mul_next;
    end

    // ---------------- rounding, saturation, output register ----------------
    logic signed [PW-1:0] ra;
    logic signed [PW-1:0] rb;
    logic signed [PW-1:0] ang_w;
    logic signed [RW-1:0] out_a_next;
    logic signed [RW-1:0] out_b_next;
    logic signed [RW-1:0] out_a_reg;
    logic signed [RW-1:0] out_b_reg;
    prc_pkg::req_type_t   out_mode_reg;
    logic                 out_zero_reg;

    always_comb
    begin
        ra    = (mul_reg.pa + OUT_RND) >>> prc_pkg::COMP_SHIFT;
        rb    = (mul_reg.pb + OUT_RND) >>> prc_pkg::COMP_SHIFT;
        ang_w = PW'(mul_reg.ang);
        priority if (mul_reg.mode == prc_pkg::REQ_POLAR_TO_RECT)
        begin
            out_a_next = sat(ra, -OUT_MAX_W, OUT_MAX_W);
            out_b_next = sat(rb, -OUT_MAX_W, OUT_MAX_W);
        end
        else if (mul_reg.zero)
        begin
            out_a_next = '0;
            out_b_next = '0;
        end
        else
        begin
            out_a_next = sat(ra, '0, OUT_MAX_W);
            out_b_next = sat(ang_w, -ANGLE_MAX_W, ANGLE_MAX_W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[NST-1])
        begin
            out_a_reg    <= out_a_next;
            out_b_reg    <= out_b_next;
            out_mode_reg <= mul_reg.mode;
            out_zero_reg <= mul_reg.zero;
        end
    end

    assign rsp.out_a = out_a_reg;
    assign rsp.out_b = out_b_reg;

    // ---------------- assertions ----------------
    `PRC_ASSERT_NEXT(a_accept_enters, clk, rst_n, req.valid && req.ready, vld_reg[0], "accepted transfer did not enter stage 0")
    `PRC_ASSERT_NEXT(a_mul_to_out, clk, rst_n, vld_reg[NST-2] && rdy[NST-1], rsp.valid, "multiply stage result lost before output")
    `PRC_ASSERT_NOW(a_polar_range, clk, rst_n, rsp.valid && out_mode_reg == prc_pkg::REQ_RECT_TO_POLAR, out_a_reg >= 0 && out_b_reg <= ANGLE_MAX_S && out_b_reg >= -ANGLE_MAX_S, "polar result out of range")
    `PRC_ASSERT_NOW(a_origin_zero, clk, rst_n, rsp.valid && out_mode_reg == prc_pkg::REQ_RECT_TO_POLAR && out_zero_reg, out_a_reg == 0 && out_b_reg == 0, "origin did not give zero result")
    `PRC_ASSERT_NOW(a_saturated, clk, rst_n, rsp.valid, out_a_reg <= OUT_MAX_S && out_a_reg >= -OUT_MAX_S && out_b_reg <= OUT_MAX_S && out_b_reg >= -OUT_MAX_S, "result exceeds saturation limit")

endmodule
